// ===== design/skt_pkg.sv =====
// Package for the sorted key table.
// Holds the default sizes, the operation and status codes, the controller states
// and the output control struct. It depends on nothing.
package skt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned KEY_BITS_DEF = 31;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS_SCAN,
    S_INS_HEAD,
    S_DEL_SCAN,
    S_DUMP,
    S_FIN
  } state_e;

  typedef struct packed {
    logic    ld;
    status_e status;
    logic    last;
  } out_ctl_t;

endpackage

// ===== design/skt_if.sv =====
// Handshake channels of the sorted key table: the command channel and the result channel.
// Each carries valid, ready and the word. Depends on skt_pkg for default widths.
interface skt_in_if import skt_pkg::*; #(
  parameter int unsigned KEY_W = KEY_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [KEY_W-1:0] key;

  modport source (output valid, kind, key, input ready);
  modport sink (input valid, kind, key, output ready);
endinterface

interface skt_out_if import skt_pkg::*; #(
  parameter int unsigned KEY_W = KEY_BITS_DEF,
  parameter int unsigned CNT_W = $clog2(CAPACITY_DEF + 1)
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [KEY_W-1:0] entry_key;
  logic [CNT_W-1:0] entry_count;
  logic             last;

  modport source (output valid, status, entry_key, entry_count, last, input ready);
  modport sink (input valid, status, entry_key, entry_count, last, output ready);
endinterface

// ===== design/skt_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module skt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/skt_ctrl.sv =====
// Controller of the sorted key table: scans the key RAM, shifts entries on insert and
// delete, streams them on dump and keeps the key count.
// Depends on skt_pkg and skt_in_if.
module skt_ctrl import skt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  skt_in_if.sink              in_i,
  input  logic                out_free_i,
  input  logic [KEY_BITS-1:0] rd_data_i,
  output logic                ram_we_o,
  output logic [AW-1:0]       ram_waddr_o,
  output logic [KEY_BITS-1:0] ram_wdata_o,
  output logic                ram_re_o,
  output logic [AW-1:0]       ram_raddr_o,
  output out_ctl_t            out_ctl_o,
  output logic [KEY_BITS-1:0] out_key_o,
  output logic [CW-1:0]       out_count_o
);

  state_e              state_q, state_d;
  kind_e               op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       count_q, count_d;
  logic                found_q, found_d;
  status_e             status_q, status_d;
  logic [AW-1:0]       last_idx;
  logic                is_full;
  logic                is_empty;
  logic                at_last;
  logic                not_smaller;
  logic                hit;

  assign last_idx    = AW'(count_q - CW'(1));
  assign is_full     = (count_q == CW'(CAPACITY));
  assign is_empty    = (count_q == '0);
  assign at_last     = (idx_q == last_idx);
  assign not_smaller = (rd_data_i >= key_q);
  assign hit         = (rd_data_i == key_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_START;
        end
      end
      S_START: begin
        unique case (op_q)
          KIND_INSERT: begin
            if (is_full) begin
              state_d = S_FIN;
            end else if (is_empty) begin
              state_d = S_INS_HEAD;
            end else begin
              state_d = S_INS_SCAN;
            end
          end
          KIND_DELETE: state_d = is_empty ? S_FIN : S_DEL_SCAN;
          KIND_DUMP:   state_d = is_empty ? S_FIN : S_DUMP;
          KIND_NOP:    state_d = S_FIN;
          default:     state_d = S_FIN;
        endcase
      end
      S_INS_SCAN: begin
        if (!not_smaller) begin
          state_d = S_FIN;
        end else if (idx_q == '0) begin
          state_d = S_INS_HEAD;
        end
      end
      S_INS_HEAD: state_d = S_FIN;
      S_DEL_SCAN: begin
        if (at_last) begin
          state_d = S_FIN;
        end
      end
      S_DUMP: begin
        if (out_free_i && at_last) begin
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q + AW'(1);
    ram_wdata_o = rd_data_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;
    op_d        = op_q;
    key_d       = key_q;
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    status_d    = status_q;
    out_ctl_o   = '{ld: 1'b0, status: ST_OK, last: 1'b0};
    out_key_o   = '0;
    out_count_o = count_q;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d  = kind_e'(in_i.kind);
          key_d = in_i.key;
        end
      end
      S_START: begin
        status_d = ST_OK;
        found_d  = 1'b0;
        unique case (op_q)
          KIND_INSERT: begin
            if (is_full) begin
              status_d = ST_FULL;
            end else if (!is_empty) begin
              ram_re_o    = 1'b1;
              ram_raddr_o = last_idx;
              idx_d       = last_idx;
            end
          end
          KIND_DELETE, KIND_DUMP: begin
            if (is_empty) begin
              status_d = (op_q == KIND_DUMP) ? ST_EMPTY : ST_NOT_FOUND;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = '0;
              idx_d       = '0;
            end
          end
          default: status_d = ST_OK;
        endcase
      end
      S_INS_SCAN: begin
        ram_we_o = 1'b1;
        if (not_smaller) begin
          if (idx_q != '0) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = idx_q - AW'(1);
            idx_d       = idx_q - AW'(1);
          end
        end else begin
          ram_wdata_o = key_q;
          count_d     = count_q + CW'(1);
        end
      end
      S_INS_HEAD: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
        ram_wdata_o = key_q;
        count_d     = count_q + CW'(1);
      end
      S_DEL_SCAN: begin
        if (found_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = idx_q - AW'(1);
        end else if (hit) begin
          found_d = 1'b1;
        end
        if (at_last) begin
          if (found_q || hit) begin
            count_d = count_q - CW'(1);
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_q + AW'(1);
          idx_d       = idx_q + AW'(1);
        end
      end
      S_DUMP: begin
        if (out_free_i) begin
          out_ctl_o = '{ld: 1'b1, status: ST_OK, last: at_last};
          out_key_o = rd_data_i;
          if (!at_last) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = idx_q + AW'(1);
            idx_d       = idx_q + AW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          out_ctl_o = '{ld: 1'b1, status: status_q, last: 1'b1};
        end
      end
      default: in_i.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    status_q <= status_d;
  end

`ifndef ASSERT_OFF
  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o && ram_re_o |-> ram_waddr_o != ram_raddr_o)
    else $error("RAM read and write hit the same entry in one cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("Key count exceeds the table capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(state_q) == S_INS_SCAN ||
      $past(state_q) == S_INS_HEAD || $past(state_q) == S_DEL_SCAN)
    else $error("Key count changed outside an insert or delete");

  a_ld_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ctl_o.ld |-> state_q == S_DUMP || state_q == S_FIN)
    else $error("Result word loaded outside a dump or finish step");
`endif

endmodule

// ===== design/sorted_key_table.sv =====
// Sorted key table top level: the key RAM, the controller and the result register.
// Depends on skt_pkg, skt_if, skt_ram and skt_ctrl.
//
//   channel  dir  word fields                              accepted when
//   in_i     in   kind, key                                valid && ready
//   out_o    out  status, entry_key, entry_count, last     valid && ready
//
// On an insert the RAM is scanned downward one entry per cycle while each key not smaller
// moves up one place. A delete always scans the whole table upward.
// A dump gives one word per cycle while out_o is ready; the RAM read port sets that.
// Reset clears the count and the controller state; the RAM holds no reset value.
// A command is taken only when the previous one has finished.
module sorted_key_table import skt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  skt_in_if.sink   in_i,
  skt_out_if.source out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;
  out_ctl_t            out_ctl;
  logic [KEY_BITS-1:0] out_key;
  logic [CW-1:0]       out_count;
  logic                out_free;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [KEY_BITS-1:0] out_key_q;
  logic [CW-1:0]       out_count_q;
  logic                out_last_q;

  skt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  skt_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_free_i  (out_free),
    .rd_data_i   (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .out_ctl_o   (out_ctl),
    .out_key_o   (out_key),
    .out_count_o (out_count)
  );

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ctl.ld) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ctl.ld) begin
      out_status_q <= out_ctl.status;
      out_key_q    <= out_key;
      out_count_q  <= out_count;
      out_last_q   <= out_ctl.last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_key   = out_key_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.last        = out_last_q;

`ifndef ASSERT_OFF
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_FULL |-> out_o.entry_count == CW'(CAPACITY))
    else $error("Full status reported while the table is not full");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_EMPTY |-> out_o.entry_count == '0 && out_o.last)
    else $error("Empty status reported with keys stored or without last");

  a_key_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.entry_key != '0 |-> out_o.status == ST_OK)
    else $error("Nonzero key in a word that does not report success");
`endif

endmodule
